// ===== rtl/core/fgk_adaptive_huffman_codec_macros.svh =====
`ifndef FGK_ADAPTIVE_HUFFMAN_CODEC_MACROS_SVH
`define FGK_ADAPTIVE_HUFFMAN_CODEC_MACROS_SVH

// check a property on every clock outside reset
`define FGK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a condition leads to a consequence in the next cycle
`define FGK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fgk_pkg.sv =====
package fgk_pkg;

   localparam int SYMBOL_COUNT_DEF = 256;
   localparam int NODE_COUNT_DEF   = 513;
   localparam int WEIGHT_BITS_DEF  = 32;
   localparam int CHUNK_BITS_DEF   = 32;
   localparam int MAX_RESULTS      = 9;
   localparam int RAW_BITS         = 8;
   localparam int RAW_MSB          = 7;
   localparam int SYM_W            = 8;

endpackage

// ===== rtl/core/fgk_adaptive_huffman_codec.sv =====
// channel  | direction | fields
// req_*    | in        | func, symbol_in, code_bit
// rsp_*    | out       | code_chunk, chunk_bits, last_chunk, symbol_valid,
//          |           | decoded_symbol, weight_overflow
// One request at a time. Encode: walk up from the leaf to build the path, then
// the update pass; decode: shift in a raw bit at the escape node or take a tree step,
// and the update pass once a symbol completes. Using the node and link memories, the
// update pass finds each level's block leader, may swap with it, and bumps the weight.
// After reset the node memory and the leaf links clear before req_ready rises.
// A stalled rsp channel holds the next chunk; the next request waits until the last chunk
// sits in the output register.
`include "fgk_adaptive_huffman_codec_macros.svh"
module fgk_adaptive_huffman_codec
   import fgk_pkg::*;
#(
   parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
   parameter int NODE_COUNT   = NODE_COUNT_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
   parameter int CHUNK_BITS   = CHUNK_BITS_DEF,
   localparam int CNT_W       = $clog2(CHUNK_BITS + 1)
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [SYM_W-1:0]      req_symbol_in,
   input  logic                  req_code_bit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHUNK_BITS-1:0] rsp_code_chunk,
   output logic [CNT_W-1:0]      rsp_chunk_bits,
   output logic                  rsp_last_chunk,
   output logic                  rsp_symbol_valid,
   output logic [SYM_W-1:0]      rsp_decoded_symbol,
   output logic                  rsp_weight_overflow
);

   localparam int IDX_W = $clog2(NODE_COUNT + 1);
   localparam int LA_W  = $clog2(NODE_COUNT + 1 + SYMBOL_COUNT);
   localparam logic [IDX_W-1:0] ROOT = IDX_W'(NODE_COUNT);

   typedef struct packed {
      logic [IDX_W-1:0]       left;
      logic [IDX_W-1:0]       right;
      logic [WEIGHT_BITS-1:0] weight;
      logic [SYM_W-1:0]       symbol;
   } node_word_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      node_word_type    wr_word;
   } node_req_type;

   typedef struct packed {
      logic             rd_en;
      logic [LA_W-1:0]  rd_addr;
      logic             wr_en;
      logic [LA_W-1:0]  wr_addr;
      logic [IDX_W-1:0] wr_data;
   } link_req_type;

   typedef struct packed {
      logic             clear;
      logic             raw_en;
      logic             push;
      logic             push_bit;
      logic             emit;
      logic             dec;
      logic             got;
      logic [SYM_W-1:0] sym;
   } pk_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_E_LEAF, ST_E_PAR, ST_E_CHILD, ST_E_WALKED,
      ST_A_CHK, ST_A_WE, ST_A_WL, ST_A_WN, ST_A_LS,
      ST_U_CHK, ST_U_RDP, ST_U_RDQ, ST_U_SCAN, ST_U_PH, ST_U_SW, ST_U_WB, ST_U_FIX,
      ST_D_START, ST_D_NX, ST_D_LF, ST_FIN, ST_DRAIN
   } state_type;

   function automatic logic valid_pos(input logic [IDX_W-1:0] x);
      return (x != '0) && (x <= ROOT);
   endfunction

   function automatic logic [LA_W-1:0] leaf_addr(input logic [SYM_W-1:0] s);
      return LA_W'(NODE_COUNT + 1) + LA_W'(s);
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] inc_sat(input logic [WEIGHT_BITS-1:0] w);
      return (w == '1) ? w : w + WEIGHT_BITS'(1);
   endfunction

   node_req_type node_req;
   link_req_type link_req;
   pk_cmd_type pk_cmd;
   node_word_type node_rd;
   logic [IDX_W-1:0] link_rd;
   logic clear_busy, pk_busy;

   state_type state_ff, state_in;
   logic func_ff, func_in, bit_ff, bit_in, seen_ff, seen_in;
   logic got_ff, got_in, ovf_ff, ovf_in;
   logic [SYM_W-1:0] sym_ff, sym_in, dsym_ff, dsym_in, raw_ff, raw_in;
   logic [3:0] rawcnt_ff, rawcnt_in;
   logic [IDX_W-1:0] start_ff, start_in, n_ff, n_in, p_ff, p_in, esc_ff, esc_in;
   logic [IDX_W-1:0] wp_ff, wp_in, h_ff, h_in, i_ff, i_in;
   logic [IDX_W-1:0] parn_ff, parn_in, parh_ff, parh_in;
   node_word_type wn_ff, wn_in, wh_ff, wh_in;
   logic [2:0] fix_ff, fix_in;

   logic seen_now, swapped;
   logic [IDX_W-1:0] n0, nx;
   logic [SYM_W-1:0] nraw;
   logic [3:0] ncnt;
   node_word_type w;

   assign req_ready = (state_ff == ST_IDLE) && !clear_busy;

   fgk_node_store #(
      .NODE_COUNT(NODE_COUNT),
      .SYMBOL_COUNT(SYMBOL_COUNT),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .node_req_bus(node_req),
      .node_rd_word(node_rd),
      .link_req_bus(link_req),
      .link_rd_data(link_rd),
      .clear_busy(clear_busy)
   );

   fgk_path_packer #(
      .NODE_COUNT(NODE_COUNT),
      .CHUNK_BITS(CHUNK_BITS)
   ) u_packer (
      .clock(clock),
      .reset(reset),
      .cmd_bus(pk_cmd),
      .overflow(ovf_ff),
      .busy(pk_busy),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_code_chunk(rsp_code_chunk),
      .rsp_chunk_bits(rsp_chunk_bits),
      .rsp_last_chunk(rsp_last_chunk),
      .rsp_symbol_valid(rsp_symbol_valid),
      .rsp_decoded_symbol(rsp_decoded_symbol),
      .rsp_weight_overflow(rsp_weight_overflow)
   );

   always_comb begin
      state_in = state_ff;
      func_in = func_ff;
      bit_in = bit_ff;
      seen_in = seen_ff;
      got_in = got_ff;
      sym_in = sym_ff;
      dsym_in = dsym_ff;
      raw_in = raw_ff;
      rawcnt_in = rawcnt_ff;
      start_in = start_ff;
      n_in = n_ff;
      p_in = p_ff;
      esc_in = esc_ff;
      wp_in = wp_ff;
      h_in = h_ff;
      i_in = i_ff;
      parn_in = parn_ff;
      parh_in = parh_ff;
      wn_in = wn_ff;
      wh_in = wh_ff;
      fix_in = fix_ff;
      node_req = '0;
      link_req = '0;
      pk_cmd = '0;
      w = node_rd;
      seen_now = (int'(sym_ff) < SYMBOL_COUNT) && valid_pos(link_rd);
      n0 = seen_now ? link_rd : esc_ff;
      nx = bit_ff ? node_rd.left : node_rd.right;
      nraw = {raw_ff[RAW_MSB-1:0], bit_ff};
      ncnt = rawcnt_ff + 4'd1;
      swapped = !((n_ff == ROOT) || (h_ff == ROOT) || (n_ff == h_ff) ||
                  (parn_ff == h_ff) || (link_rd == n_ff));
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               func_in = req_func;
               sym_in = req_symbol_in;
               bit_in = req_code_bit;
               got_in = 1'b0;
               dsym_in = '0;
               if (!req_func) begin
                  if (int'(req_symbol_in) < SYMBOL_COUNT) begin
                     link_req.rd_en = 1'b1;
                     link_req.rd_addr = leaf_addr(req_symbol_in);
                  end
                  state_in = ST_E_LEAF;
               end else begin
                  state_in = ST_D_START;
               end
            end
         end
         ST_E_LEAF: begin
            seen_in = seen_now;
            start_in = n0;
            n_in = n0;
            pk_cmd.clear = 1'b1;
            pk_cmd.raw_en = !seen_now;
            pk_cmd.sym = sym_ff;
            if (n0 == ROOT) begin
               state_in = ST_E_WALKED;
            end else begin
               link_req.rd_en = 1'b1;
               link_req.rd_addr = LA_W'(n0);
               state_in = ST_E_PAR;
            end
         end
         ST_E_PAR: begin
            if (!valid_pos(link_rd)) begin
               state_in = ST_E_WALKED;
            end else begin
               p_in = link_rd;
               node_req.rd_en = 1'b1;
               node_req.rd_addr = link_rd;
               state_in = ST_E_CHILD;
            end
         end
         ST_E_CHILD: begin
            pk_cmd.push = 1'b1;
            pk_cmd.push_bit = (node_rd.left == n_ff);
            n_in = p_ff;
            if (p_ff == ROOT) begin
               state_in = ST_E_WALKED;
            end else begin
               link_req.rd_en = 1'b1;
               link_req.rd_addr = LA_W'(p_ff);
               state_in = ST_E_PAR;
            end
         end
         ST_E_WALKED: begin
            if (seen_ff) begin
               n_in = start_ff;
               state_in = ST_U_CHK;
            end else begin
               state_in = ST_A_CHK;
            end
         end
         ST_A_CHK: begin
            if ((esc_ff < IDX_W'(3)) || (int'(sym_ff) >= SYMBOL_COUNT)) begin
               state_in = ST_FIN;
            end else begin
               node_req.rd_en = 1'b1;
               node_req.rd_addr = esc_ff;
               state_in = ST_A_WE;
            end
         end
         ST_A_WE: begin
            w.left = esc_ff - IDX_W'(1);
            w.right = esc_ff - IDX_W'(2);
            node_req.wr_en = 1'b1;
            node_req.wr_addr = esc_ff;
            node_req.wr_word = w;
            state_in = ST_A_WL;
         end
         ST_A_WL: begin
            w = '0;
            w.symbol = sym_ff;
            node_req.wr_en = 1'b1;
            node_req.wr_addr = esc_ff - IDX_W'(1);
            node_req.wr_word = w;
            link_req.wr_en = 1'b1;
            link_req.wr_addr = LA_W'(esc_ff - IDX_W'(1));
            link_req.wr_data = esc_ff;
            state_in = ST_A_WN;
         end
         ST_A_WN: begin
            node_req.wr_en = 1'b1;
            node_req.wr_addr = esc_ff - IDX_W'(2);
            node_req.wr_word = '0;
            link_req.wr_en = 1'b1;
            link_req.wr_addr = LA_W'(esc_ff - IDX_W'(2));
            link_req.wr_data = esc_ff;
            state_in = ST_A_LS;
         end
         ST_A_LS: begin
            link_req.wr_en = 1'b1;
            link_req.wr_addr = leaf_addr(sym_ff);
            link_req.wr_data = esc_ff - IDX_W'(1);
            esc_in = esc_ff - IDX_W'(2);
            n_in = esc_ff - IDX_W'(1);
            state_in = ST_U_CHK;
         end
         ST_U_CHK: begin
            if (!valid_pos(n_ff)) begin
               state_in = ST_FIN;
            end else begin
               node_req.rd_en = 1'b1;
               node_req.rd_addr = n_ff;
               state_in = ST_U_RDP;
            end
         end
         ST_U_RDP: begin
            wn_in = node_rd;
            link_req.rd_en = 1'b1;
            link_req.rd_addr = LA_W'(n_ff);
            state_in = ST_U_RDQ;
         end
         ST_U_RDQ: begin
            parn_in = link_rd;
            h_in = n_ff;
            wh_in = wn_ff;
            if (n_ff == ROOT) begin
               state_in = ST_U_PH;
            end else begin
               i_in = n_ff + IDX_W'(1);
               node_req.rd_en = 1'b1;
               node_req.rd_addr = n_ff + IDX_W'(1);
               state_in = ST_U_SCAN;
            end
         end
         ST_U_SCAN: begin
            if (node_rd.weight == wn_ff.weight) begin
               h_in = i_ff;
               wh_in = node_rd;
               if (i_ff == ROOT) begin
                  state_in = ST_U_PH;
               end else begin
                  i_in = i_ff + IDX_W'(1);
                  node_req.rd_en = 1'b1;
                  node_req.rd_addr = i_ff + IDX_W'(1);
               end
            end else begin
               state_in = ST_U_PH;
            end
         end
         ST_U_PH: begin
            link_req.rd_en = 1'b1;
            link_req.rd_addr = LA_W'(h_ff);
            state_in = ST_U_SW;
         end
         ST_U_SW: begin
            parh_in = link_rd;
            node_req.wr_en = 1'b1;
            node_req.wr_addr = n_ff;
            if (swapped) begin
               node_req.wr_word = wh_ff;
               if (esc_ff == n_ff) begin
                  esc_in = h_ff;
               end else if (esc_ff == h_ff) begin
                  esc_in = n_ff;
               end
               fix_in = '0;
               state_in = ST_U_WB;
            end else begin
               w = wn_ff;
               w.weight = inc_sat(wn_ff.weight);
               node_req.wr_word = w;
               n_in = (n_ff == ROOT) ? '0 : parn_ff;
               state_in = ST_U_CHK;
            end
         end
         ST_U_WB: begin
            w = wn_ff;
            w.weight = inc_sat(wn_ff.weight);
            node_req.wr_en = 1'b1;
            node_req.wr_addr = h_ff;
            node_req.wr_word = w;
            state_in = ST_U_FIX;
         end
         ST_U_FIX: begin
            fix_in = fix_ff + 3'd1;
            case (fix_ff)
               3'd0: begin
                  link_req.wr_en = valid_pos(wh_ff.left);
                  link_req.wr_addr = LA_W'(wh_ff.left);
                  link_req.wr_data = n_ff;
               end
               3'd1: begin
                  link_req.wr_en = valid_pos(wh_ff.right);
                  link_req.wr_addr = LA_W'(wh_ff.right);
                  link_req.wr_data = n_ff;
               end
               3'd2: begin
                  link_req.wr_en = (wh_ff.left == '0) && (n_ff != esc_ff) &&
                                   (int'(wh_ff.symbol) < SYMBOL_COUNT);
                  link_req.wr_addr = leaf_addr(wh_ff.symbol);
                  link_req.wr_data = n_ff;
               end
               3'd3: begin
                  link_req.wr_en = valid_pos(wn_ff.left);
                  link_req.wr_addr = LA_W'(wn_ff.left);
                  link_req.wr_data = h_ff;
               end
               3'd4: begin
                  link_req.wr_en = valid_pos(wn_ff.right);
                  link_req.wr_addr = LA_W'(wn_ff.right);
                  link_req.wr_data = h_ff;
               end
               default: begin
                  link_req.wr_en = (wn_ff.left == '0) && (h_ff != esc_ff) &&
                                   (int'(wn_ff.symbol) < SYMBOL_COUNT);
                  link_req.wr_addr = leaf_addr(wn_ff.symbol);
                  link_req.wr_data = h_ff;
                  n_in = parh_ff;
                  state_in = ST_U_CHK;
               end
            endcase
         end
         ST_D_START: begin
            if (wp_ff == esc_ff) begin
               if (ncnt >= 4'(RAW_BITS)) begin
                  got_in = 1'b1;
                  dsym_in = nraw;
                  sym_in = nraw;
                  raw_in = '0;
                  rawcnt_in = '0;
                  wp_in = ROOT;
                  state_in = ST_A_CHK;
               end else begin
                  raw_in = nraw;
                  rawcnt_in = ncnt;
                  state_in = ST_FIN;
               end
            end else begin
               node_req.rd_en = 1'b1;
               node_req.rd_addr = wp_ff;
               state_in = ST_D_NX;
            end
         end
         ST_D_NX: begin
            if (!valid_pos(nx)) begin
               wp_in = ROOT;
               state_in = ST_FIN;
            end else begin
               wp_in = nx;
               node_req.rd_en = 1'b1;
               node_req.rd_addr = nx;
               state_in = ST_D_LF;
            end
         end
         ST_D_LF: begin
            if ((node_rd.left == '0) && (wp_ff != esc_ff)) begin
               got_in = 1'b1;
               dsym_in = node_rd.symbol;
               wp_in = ROOT;
               n_in = wp_ff;
               state_in = ST_U_CHK;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            pk_cmd.emit = 1'b1;
            pk_cmd.dec = func_ff;
            pk_cmd.got = got_ff;
            pk_cmd.sym = dsym_ff;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pk_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ovf_in = ovf_ff;
      if (node_req.wr_en && (node_req.wr_addr == ROOT)) begin
         ovf_in = (node_req.wr_word.weight == '1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         esc_ff <= ROOT;
         wp_ff <= ROOT;
         raw_ff <= '0;
         rawcnt_ff <= '0;
         ovf_ff <= 1'b0;
         got_ff <= 1'b0;
         fix_ff <= '0;
      end else begin
         state_ff <= state_in;
         esc_ff <= esc_in;
         wp_ff <= wp_in;
         raw_ff <= raw_in;
         rawcnt_ff <= rawcnt_in;
         ovf_ff <= ovf_in;
         got_ff <= got_in;
         fix_ff <= fix_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      bit_ff <= bit_in;
      seen_ff <= seen_in;
      sym_ff <= sym_in;
      dsym_ff <= dsym_in;
      start_ff <= start_in;
      n_ff <= n_in;
      p_ff <= p_in;
      h_ff <= h_in;
      i_ff <= i_in;
      parn_ff <= parn_in;
      parh_ff <= parh_in;
      wn_ff <= wn_in;
      wh_ff <= wh_in;
   end

   `FGK_ASSERT(a_esc_in_table, valid_pos(esc_ff), "escape node left the table")
   `FGK_ASSERT(a_node_wr_range, node_req.wr_en |-> valid_pos(node_req.wr_addr), "bad node write")
   `FGK_ASSERT(a_empty_is_last, (rsp_valid && (rsp_chunk_bits == '0)) |-> rsp_last_chunk, "empty")
   `FGK_ASSERT_NEXT(a_emit_starts, state_ff == ST_FIN, pk_busy, "packer did not start on emit")

endmodule

// ===== rtl/core/fgk_node_store.sv =====
module fgk_node_store
   import fgk_pkg::*;
#(
   parameter int NODE_COUNT   = NODE_COUNT_DEF,
   parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
   localparam int IDX_W       = $clog2(NODE_COUNT + 1),
   localparam int LINK_DEPTH  = NODE_COUNT + 1 + SYMBOL_COUNT,
   localparam int LA_W        = $clog2(LINK_DEPTH),
   localparam int WORD_W      = 2 * IDX_W + WEIGHT_BITS + SYM_W,
   localparam int NREQ_W      = 2 + 2 * IDX_W + WORD_W,
   localparam int LREQ_W      = 2 + 2 * LA_W + IDX_W
)(
   input  logic              clock,
   input  logic              reset,
   input  logic [NREQ_W-1:0] node_req_bus,
   output logic [WORD_W-1:0] node_rd_word,
   input  logic [LREQ_W-1:0] link_req_bus,
   output logic [IDX_W-1:0]  link_rd_data,
   output logic              clear_busy
);

   typedef struct packed {
      logic [IDX_W-1:0]       left;
      logic [IDX_W-1:0]       right;
      logic [WEIGHT_BITS-1:0] weight;
      logic [SYM_W-1:0]       symbol;
   } node_word_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      node_word_type    wr_word;
   } node_req_type;

   typedef struct packed {
      logic             rd_en;
      logic [LA_W-1:0]  rd_addr;
      logic             wr_en;
      logic [LA_W-1:0]  wr_addr;
      logic [IDX_W-1:0] wr_data;
   } link_req_type;

   node_req_type  nreq;
   link_req_type  lreq;
   node_word_type node_mem [NODE_COUNT + 1];
   logic [IDX_W-1:0] link_mem [LINK_DEPTH];
   node_word_type node_rd_ff;
   logic [IDX_W-1:0] link_rd_ff;
   logic [IDX_W-1:0] clr_ff;
   logic clear_busy_ff;

   assign nreq = node_req_type'(node_req_bus);
   assign lreq = link_req_type'(link_req_bus);
   assign node_rd_word = node_rd_ff;
   assign link_rd_data = link_rd_ff;
   assign clear_busy = clear_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clear_busy_ff <= 1'b1;
      end else if (clear_busy_ff) begin
         if (clr_ff == IDX_W'(NODE_COUNT)) begin
            clear_busy_ff <= 1'b0;
         end
         clr_ff <= clr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         node_mem[clr_ff] <= '0;
      end else if (nreq.wr_en) begin
         node_mem[nreq.wr_addr] <= nreq.wr_word;
      end
      if (nreq.rd_en) begin
         node_rd_ff <= node_mem[nreq.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         if (int'(clr_ff) < SYMBOL_COUNT) begin
            link_mem[LA_W'(NODE_COUNT + 1) + LA_W'(clr_ff)] <= '0;
         end
      end else if (lreq.wr_en) begin
         link_mem[lreq.wr_addr] <= lreq.wr_data;
      end
      if (lreq.rd_en) begin
         link_rd_ff <= link_mem[lreq.rd_addr];
      end
   end

endmodule

// ===== rtl/core/fgk_path_packer.sv =====
module fgk_path_packer
   import fgk_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF,
   parameter int CHUNK_BITS = CHUNK_BITS_DEF,
   localparam int PATH_W    = NODE_COUNT + RAW_BITS,
   localparam int BUF_W     = (PATH_W > CHUNK_BITS) ? PATH_W : CHUNK_BITS,
   localparam int LEN_W     = $clog2(PATH_W + 1),
   localparam int CNT_W     = $clog2(CHUNK_BITS + 1),
   localparam int K_W       = $clog2(MAX_RESULTS + 1),
   localparam int CMD_W     = 7 + SYM_W
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CMD_W-1:0]      cmd_bus,
   input  logic                  overflow,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHUNK_BITS-1:0] rsp_code_chunk,
   output logic [CNT_W-1:0]      rsp_chunk_bits,
   output logic                  rsp_last_chunk,
   output logic                  rsp_symbol_valid,
   output logic [SYM_W-1:0]      rsp_decoded_symbol,
   output logic                  rsp_weight_overflow
);

   typedef struct packed {
      logic             clear;
      logic             raw_en;
      logic             push;
      logic             push_bit;
      logic             emit;
      logic             dec;
      logic             got;
      logic [SYM_W-1:0] sym;
   } pk_cmd_type;

   pk_cmd_type cmd;
   logic [BUF_W-1:0] buf_ff;
   logic [LEN_W-1:0] len_ff;
   logic [K_W-1:0] k_ff;
   logic busy_ff, dec_ff, got_ff;
   logic [SYM_W-1:0] dsym_ff;
   logic valid_ff, last_ff, sv_ff, ovf_ff;
   logic [CHUNK_BITS-1:0] chunk_ff;
   logic [CNT_W-1:0] bits_ff;
   logic [SYM_W-1:0] ds_ff;

   logic load, last_enc, put_dec, put_enc;
   logic [CNT_W-1:0] cnt;
   logic [CHUNK_BITS-1:0] top_bits, value;
   logic [LEN_W-1:0] rem;

   assign cmd = pk_cmd_type'(cmd_bus);
   assign load = busy_ff && (!valid_ff || rsp_ready);
   assign put_dec = load && dec_ff;
   assign put_enc = load && !dec_ff && (len_ff != '0);
   assign cnt = (int'(len_ff) >= CHUNK_BITS) ? CNT_W'(CHUNK_BITS) : CNT_W'(len_ff);
   assign top_bits = buf_ff[BUF_W-1 -: CHUNK_BITS];
   assign value = top_bits >> (CNT_W'(CHUNK_BITS) - cnt);
   assign rem = len_ff - LEN_W'(cnt);
   assign last_enc = (rem == '0) || (k_ff == K_W'(MAX_RESULTS - 1));

   assign busy = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_code_chunk = chunk_ff;
   assign rsp_chunk_bits = bits_ff;
   assign rsp_last_chunk = last_ff;
   assign rsp_symbol_valid = sv_ff;
   assign rsp_decoded_symbol = ds_ff;
   assign rsp_weight_overflow = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         valid_ff <= 1'b0;
         len_ff <= '0;
         k_ff <= '0;
      end else begin
         if (put_dec || put_enc) begin
            valid_ff <= 1'b1;
         end else if (valid_ff && rsp_ready) begin
            valid_ff <= 1'b0;
         end
         if (cmd.clear) begin
            buf_ff <= cmd.raw_en ? {cmd.sym, (BUF_W - SYM_W)'(0)} : '0;
            len_ff <= cmd.raw_en ? LEN_W'(RAW_BITS) : '0;
         end else if (cmd.push) begin
            buf_ff <= {cmd.push_bit, buf_ff[BUF_W-1:1]};
            len_ff <= len_ff + LEN_W'(1);
         end else if (put_enc) begin
            buf_ff <= buf_ff << CHUNK_BITS;
            len_ff <= rem;
         end
         if (cmd.emit) begin
            busy_ff <= 1'b1;
            k_ff <= '0;
            dec_ff <= cmd.dec;
            got_ff <= cmd.got;
            dsym_ff <= cmd.sym;
         end else if (load) begin
            if (dec_ff || (len_ff == '0) || last_enc) begin
               busy_ff <= 1'b0;
            end
            if (put_enc) begin
               k_ff <= k_ff + K_W'(1);
            end
         end
         if (load) begin
            ovf_ff <= overflow;
         end
         if (put_dec) begin
            chunk_ff <= '0;
            bits_ff <= '0;
            last_ff <= 1'b1;
            sv_ff <= got_ff;
            ds_ff <= got_ff ? dsym_ff : '0;
         end else if (put_enc) begin
            chunk_ff <= value;
            bits_ff <= cnt;
            last_ff <= last_enc;
            sv_ff <= 1'b0;
            ds_ff <= '0;
         end
      end
   end

endmodule

// ===== tb/fgk_adaptive_huffman_codec_checker.sv =====
module fgk_adaptive_huffman_codec_checker
   import fgk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_symbol_in,
   input  logic        req_code_bit,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_code_chunk,
   input  logic [5:0]  rsp_chunk_bits,
   input  logic        rsp_last_chunk,
   input  logic        rsp_symbol_valid,
   input  logic [7:0]  rsp_decoded_symbol,
   input  logic        rsp_weight_overflow,
   output int          fail_count,
   output int          pending_count,
   output int          encode_count,
   output int          decoded_count,
   output int          escape_count,
   output int          result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = NODE_COUNT_DEF;
   localparam int SYMS  = SYMBOL_COUNT_DEF;
   localparam int CHUNK = CHUNK_BITS_DEF;
   localparam bit [31:0] WEIGHT_TOP = 32'hFFFF_FFFF;
   localparam bit [9:0] ROOT_POS = 10'(NODES);

   typedef struct packed {
      logic [31:0] code_chunk;
      logic [5:0]  chunk_bits;
      logic        last_chunk;
      logic        symbol_valid;
      logic [7:0]  decoded_symbol;
      logic        weight_overflow;
   } codec_result_t;

   codec_result_t expected_results[$];

   bit [9:0]  up_link   [0:NODES];
   bit [9:0]  left_link [0:NODES];
   bit [9:0]  right_link[0:NODES];
   bit [31:0] weight    [0:NODES];
   bit [7:0]  node_byte [0:NODES];
   bit [9:0]  leaf_at   [0:SYMS-1];
   bit [9:0]  escape_node;
   bit [9:0]  walk_node;
   bit [7:0]  raw_acc;
   bit [3:0]  raw_cnt;
   bit        code_path[0:NODES+8];

   function automatic bit in_tree(bit [9:0] p);
      return p >= 1 && p <= NODES;
   endfunction

   function automatic bit [9:0] block_leader(bit [9:0] n);
      bit [9:0] h;
      int i;
      h = n;
      for (i = n + 1; i <= NODES && weight[i] == weight[n]; i++) h = 10'(i);
      return h;
   endfunction

   function automatic void relink(bit [9:0] p);
      if (in_tree(left_link[p])) up_link[left_link[p]] = p;
      if (in_tree(right_link[p])) up_link[right_link[p]] = p;
      if (left_link[p] == 0 && p != escape_node) leaf_at[node_byte[p]] = p;
   endfunction

   function automatic void exchange(bit [9:0] a, bit [9:0] b);
      bit [31:0] tw;
      bit [9:0]  t;
      bit [7:0]  ts;
      if (a == NODES || b == NODES || a == b || up_link[a] == b || up_link[b] == a) return;
      tw = weight[a]; weight[a] = weight[b]; weight[b] = tw;
      ts = node_byte[a]; node_byte[a] = node_byte[b]; node_byte[b] = ts;
      t = left_link[a]; left_link[a] = left_link[b]; left_link[b] = t;
      t = right_link[a]; right_link[a] = right_link[b]; right_link[b] = t;
      if (escape_node == a) escape_node = b;
      else if (escape_node == b) escape_node = a;
      relink(a);
      relink(b);
   endfunction

   function automatic void bump_weights(bit [9:0] n);
      int guard;
      bit [9:0] h;
      guard = 0;
      while (in_tree(n) && guard < NODES + 1) begin
         h = block_leader(n);
         exchange(n, h);
         if (h != NODES && h != n && up_link[n] != h && up_link[h] != n) n = h;
         if (weight[n] < WEIGHT_TOP) weight[n]++;
         n = up_link[n];
         guard++;
      end
   endfunction

   function automatic void grow_tree(bit [7:0] sym);
      bit [9:0] e, lf, ne;
      e = escape_node;
      if (e < 3 || !in_tree(e)) return;
      lf = e - 10'd1;
      ne = e - 10'd2;
      left_link[e] = lf;
      right_link[e] = ne;
      up_link[lf] = e;
      up_link[ne] = e;
      left_link[lf] = '0; right_link[lf] = '0; weight[lf] = '0; node_byte[lf] = sym;
      left_link[ne] = '0; right_link[ne] = '0; weight[ne] = '0; node_byte[ne] = '0;
      leaf_at[sym] = lf;
      escape_node = ne;
      bump_weights(lf);
   endfunction

   function automatic void predict_encode(bit [7:0] sym);
      bit seen, tb;
      bit [9:0] n, p;
      int len, i, k, cnt, nchunks;
      codec_result_t r;
      seen = in_tree(leaf_at[sym]);
      n = seen ? leaf_at[sym] : escape_node;
      len = 0;
      while (in_tree(n) && n != NODES && len < NODES) begin
         p = up_link[n];
         if (!in_tree(p)) break;
         code_path[len] = (left_link[p] == n);
         len++;
         n = p;
      end
      for (i = 0; i < len / 2; i++) begin
         tb = code_path[i];
         code_path[i] = code_path[len - 1 - i];
         code_path[len - 1 - i] = tb;
      end
      if (!seen) begin
         for (i = 0; i < RAW_BITS; i++) begin
            code_path[len] = sym[RAW_MSB - i];
            len++;
         end
         grow_tree(sym);
         escape_count++;
      end else begin
         bump_weights(leaf_at[sym]);
      end
      nchunks = (len + CHUNK - 1) / CHUNK;
      if (nchunks > MAX_RESULTS) nchunks = MAX_RESULTS;
      for (k = 0; k < nchunks; k++) begin
         cnt = len - k * CHUNK;
         if (cnt > CHUNK) cnt = CHUNK;
         r = '0;
         for (i = 0; i < cnt; i++) r.code_chunk = {r.code_chunk[30:0], code_path[k * CHUNK + i]};
         r.chunk_bits = 6'(cnt);
         r.last_chunk = (k + 1 == nchunks);
         r.weight_overflow = (weight[NODES] == WEIGHT_TOP);
         expected_results.insert(expected_results.size(), r);
      end
   endfunction

   function automatic void predict_decode(bit b);
      bit [9:0] nx;
      codec_result_t r;
      r = '0;
      if (!in_tree(walk_node)) walk_node = ROOT_POS;
      if (walk_node == escape_node) begin
         raw_acc = {raw_acc[6:0], b};
         raw_cnt = raw_cnt + 4'd1;
         if (raw_cnt >= RAW_BITS) begin
            r.symbol_valid = 1'b1;
            r.decoded_symbol = raw_acc;
            raw_acc = '0;
            raw_cnt = '0;
            grow_tree(r.decoded_symbol);
            walk_node = ROOT_POS;
         end
      end else begin
         nx = b ? left_link[walk_node] : right_link[walk_node];
         if (!in_tree(nx)) begin
            walk_node = ROOT_POS;
         end else begin
            walk_node = nx;
            if (left_link[nx] == 0 && nx != escape_node) begin
               r.symbol_valid = 1'b1;
               r.decoded_symbol = node_byte[nx];
               bump_weights(nx);
               walk_node = ROOT_POS;
            end
         end
      end
      if (r.symbol_valid) decoded_count++;
      r.last_chunk = 1'b1;
      r.weight_overflow = (weight[NODES] == WEIGHT_TOP);
      expected_results.insert(expected_results.size(), r);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      int i;
      for (i = 0; i <= NODES; i++) begin
         up_link[i] = '0; left_link[i] = '0; right_link[i] = '0;
         weight[i] = '0; node_byte[i] = '0;
      end
      for (i = 0; i < SYMS; i++) leaf_at[i] = '0;
      escape_node = ROOT_POS;
      walk_node = ROOT_POS;
      raw_acc = '0;
      raw_cnt = '0;
      fail_count = 0;
      pending_count = 0;
      encode_count = 0;
      decoded_count = 0;
      escape_count = 0;
      result_count = 0;
   end

   always @(posedge clock) begin
      codec_result_t want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_func) begin
               predict_decode(req_code_bit);
            end else begin
               predict_encode(req_symbol_in);
               encode_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_code_chunk, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_code_chunk !== want.code_chunk)
                  report_mismatch("code_chunk", rsp_code_chunk, want.code_chunk);
               if (rsp_chunk_bits !== want.chunk_bits)
                  report_mismatch("chunk_bits", 32'(rsp_chunk_bits), 32'(want.chunk_bits));
               if (rsp_last_chunk !== want.last_chunk)
                  report_mismatch("last_chunk", 32'(rsp_last_chunk), 32'(want.last_chunk));
               if (rsp_symbol_valid !== want.symbol_valid)
                  report_mismatch("symbol_valid", 32'(rsp_symbol_valid),
                                  32'(want.symbol_valid));
               if (rsp_decoded_symbol !== want.decoded_symbol)
                  report_mismatch("decoded_symbol", 32'(rsp_decoded_symbol),
                                  32'(want.decoded_symbol));
               if (rsp_weight_overflow !== want.weight_overflow)
                  report_mismatch("weight_overflow", 32'(rsp_weight_overflow),
                                  32'(want.weight_overflow));
            end
         end
         pending_count = expected_results.size();
      end
   end

endmodule

// ===== tb/fgk_adaptive_huffman_codec_test.sv =====
module fgk_adaptive_huffman_codec_test;
   import fgk_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int RANDOM_ITEMS = 250;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [7:0]  req_symbol_in;
   logic        req_code_bit;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_code_chunk;
   logic [5:0]  rsp_chunk_bits;
   logic        rsp_last_chunk;
   logic        rsp_symbol_valid;
   logic [7:0]  rsp_decoded_symbol;
   logic        rsp_weight_overflow;

   int fail_count, pending_count, encode_count, decoded_count, escape_count, result_count;
   int send_idle_pct, recv_idle_pct;
   int sent_count;
   int cycles;
   bit stall_done;

   fgk_adaptive_huffman_codec u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_symbol_in(req_symbol_in), .req_code_bit(req_code_bit),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_code_chunk(rsp_code_chunk),
      .rsp_chunk_bits(rsp_chunk_bits), .rsp_last_chunk(rsp_last_chunk),
      .rsp_symbol_valid(rsp_symbol_valid), .rsp_decoded_symbol(rsp_decoded_symbol),
      .rsp_weight_overflow(rsp_weight_overflow)
   );

   fgk_adaptive_huffman_codec_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_symbol_in(req_symbol_in), .req_code_bit(req_code_bit),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_code_chunk(rsp_code_chunk),
      .rsp_chunk_bits(rsp_chunk_bits), .rsp_last_chunk(rsp_last_chunk),
      .rsp_symbol_valid(rsp_symbol_valid), .rsp_decoded_symbol(rsp_decoded_symbol),
      .rsp_weight_overflow(rsp_weight_overflow),
      .fail_count(fail_count), .pending_count(pending_count),
      .encode_count(encode_count), .decoded_count(decoded_count),
      .escape_count(escape_count), .result_count(result_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("fgk_adaptive_huffman_codec_test failed");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      stall_done = 0;
      forever begin
         @(negedge clock);
         if (!stall_done && sent_count >= 120) begin
            stall_done = 1;
            rsp_ready <= 1'b0;
            repeat (3000) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_request(bit func, bit [7:0] sym, bit code_bit);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_symbol_in <= sym;
      req_code_bit <= code_bit;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic encode_byte(bit [7:0] sym);
      send_request(1'b0, sym, 1'($urandom_range(1)));
   endtask

   task automatic decode_bit(bit b);
      send_request(1'b1, 8'($urandom_range(255)), b);
   endtask

   initial begin
      int i, j, run;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_symbol_in = '0;
      req_code_bit = 1'b0;
      sent_count = 0;
      send_idle_pct = 23;
      recv_idle_pct = 76;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      encode_byte(8'h00);
      encode_byte(8'hFF);
      encode_byte(8'h00);
      encode_byte(8'hFF);
      encode_byte(8'h80);
      encode_byte(8'h01);
      encode_byte(8'h55);
      encode_byte(8'hAA);
      encode_byte(8'h00);
      for (i = 0; i < 8; i++) decode_bit(i[0]);
      for (i = 0; i < 8; i++) decode_bit(1'($urandom_range(1)));

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < RANDOM_ITEMS / 3) begin
            send_idle_pct = 23;
            recv_idle_pct = 76;
         end else if (i < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 76;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if ($urandom_range(99) < 65) begin
            if ($urandom_range(1)) encode_byte(8'($urandom_range(255)));
            else encode_byte(8'($urandom_range(15)));
         end else begin
            run = $urandom_range(12, 1);
            for (j = 0; j < run; j++) decode_bit(1'($urandom_range(1)));
            i += run - 1;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      recv_idle_pct = 0;

      while (pending_count != 0) @(posedge clock);
      repeat (2000) @(posedge clock);

      $display("covered %0d encodes (%0d new bytes) and %0d decode bits", encode_count,
               escape_count, sent_count - encode_count);
      $display("checked %0d results, %0d bytes decoded", result_count, decoded_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("fgk_adaptive_huffman_codec_test passed");
      end else begin
         $display("fgk_adaptive_huffman_codec_test failed");
      end
      $finish;
   end

endmodule
